>>> rtl/core/ccw_pkg.sv
// Shared types, constants and a helper function for the calendar clock.
package ccw_pkg;

  localparam int SecW   = 6;
  localparam int MinW   = 6;
  localparam int HourW  = 5;
  localparam int DayW   = 5;
  localparam int MonthW = 4;
  localparam int YearW  = 14;
  localparam int WdayW  = 3;

  localparam logic [SecW-1:0]   SEC_LAST   = 6'd59;
  localparam logic [MinW-1:0]   MIN_LAST   = 6'd59;
  localparam logic [HourW-1:0]  HOUR_LAST  = 5'd23;
  localparam logic [YearW-1:0]  YEAR_LAST  = 14'd9999;

  localparam logic [MonthW-1:0] MON_JAN = 4'd1;
  localparam logic [MonthW-1:0] MON_FEB = 4'd2;
  localparam logic [MonthW-1:0] MON_MAR = 4'd3;
  localparam logic [MonthW-1:0] MON_APR = 4'd4;
  localparam logic [MonthW-1:0] MON_MAY = 4'd5;
  localparam logic [MonthW-1:0] MON_JUN = 4'd6;
  localparam logic [MonthW-1:0] MON_JUL = 4'd7;
  localparam logic [MonthW-1:0] MON_AUG = 4'd8;
  localparam logic [MonthW-1:0] MON_SEP = 4'd9;
  localparam logic [MonthW-1:0] MON_OCT = 4'd10;
  localparam logic [MonthW-1:0] MON_NOV = 4'd11;
  localparam logic [MonthW-1:0] MON_DEC = 4'd12;

  localparam logic [SecW-1:0]   RST_SEC   = 6'd50;
  localparam logic [MinW-1:0]   RST_MIN   = 6'd59;
  localparam logic [HourW-1:0]  RST_HOUR  = 5'd23;
  localparam logic [DayW-1:0]   RST_DAY   = 5'd11;
  localparam logic [MonthW-1:0] RST_MONTH = 4'd10;
  localparam logic [YearW-1:0]  RST_YEAR  = 14'd2021;
  localparam logic [WdayW-1:0]  RST_WDAY  = 3'd1;

  localparam logic [WdayW-1:0]  WDAY_LAST = 3'd6;

  typedef struct packed {
    logic [SecW-1:0]   second;
    logic [MinW-1:0]   minute;
    logic [HourW-1:0]  hour;
    logic [DayW-1:0]   day;
    logic [MonthW-1:0] month;
    logic [YearW-1:0]  year;
  } tod_t;

  // Month term of Zeller's congruence: floor(13 * (mm + 1) / 5).
  function automatic logic [5:0] month_term(input logic [MonthW-1:0] mm);
    logic [5:0] t;
    case (mm)
      4'd0:    t = 6'd2;
      4'd1:    t = 6'd5;
      4'd2:    t = 6'd7;
      4'd3:    t = 6'd10;
      4'd4:    t = 6'd13;
      4'd5:    t = 6'd15;
      4'd6:    t = 6'd18;
      4'd7:    t = 6'd20;
      4'd8:    t = 6'd23;
      4'd9:    t = 6'd26;
      4'd10:   t = 6'd28;
      4'd11:   t = 6'd31;
      4'd12:   t = 6'd33;
      4'd13:   t = 6'd36;
      4'd14:   t = 6'd39;
      default: t = 6'd41;
    endcase
    return t;
  endfunction

endpackage

>>> rtl/core/calendar_clock_with_weekday.sv
// Calendar clock: time and date update followed by a pipelined weekday unit.
// Throughput: one item per cycle unless out_stall holds the pipeline.
// The weekday path has three register stages (divide by 100, sum, modulo 7).
// Reset (rst, synchronous) empties the pipeline and loads 23:59:50,
// October 11 2021, Monday.
module calendar_clock_with_weekday
  import ccw_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              cmd,
  input  logic [SecW-1:0]   load_second,
  input  logic [MinW-1:0]   load_minute,
  input  logic [HourW-1:0]  load_hour,
  input  logic [DayW-1:0]   load_day,
  input  logic [MonthW-1:0] load_month,
  input  logic [YearW-1:0]  load_year,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [SecW-1:0]   second,
  output logic [MinW-1:0]   minute,
  output logic [HourW-1:0]  hour,
  output logic [DayW-1:0]   day,
  output logic [MonthW-1:0] month,
  output logic [YearW-1:0]  year,
  output logic [WdayW-1:0]  weekday
);

  // Stage enables; a stage moves when it is empty or its successor moves.
  logic en1, en2, en3, en4, en5;

  // Input register.
  logic v1;
  logic cmd1;
  tod_t load1;

  // Calendar state.
  tod_t cur;
  tod_t cur_next;
  logic rc_next;

  // Weekday pipeline.
  logic                v2, v3, v4;
  tod_t                tod2, tod3, tod4;
  logic                rc2, rc3, rc4;
  logic [14:0]         yy3;
  logic [7:0]          cent3;
  logic [MonthW-1:0]   mm3;
  logic [10:0]         sum4;

  assign en5 = !out_valid || !out_stall;
  assign en4 = !v4 || en5;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign in_stall = !en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= in_valid;
    end
    if (en1 && in_valid) begin
      cmd1          <= cmd;
      load1.second  <= load_second;
      load1.minute  <= load_minute;
      load1.hour    <= load_hour;
      load1.day     <= load_day;
      load1.month   <= load_month;
      load1.year    <= load_year;
    end
  end

  // Leap year test; year % 25 is checked by a reciprocal multiply.
  logic [26:0]       y25_prod;
  logic [9:0]        y25_q;
  logic [YearW-1:0]  y25_back;
  logic              div25;
  logic              leap;
  logic [DayW-1:0]   month_len;
  logic              month_ok;

  assign y25_prod = cur.year * 13'd5243;
  assign y25_q    = y25_prod[26:17];
  assign y25_back = YearW'({y25_q, 4'b0000} + {1'b0, y25_q, 3'b000} + {4'b0000, y25_q});
  assign div25    = (y25_back == cur.year);
  assign leap     = (cur.year[1:0] == 2'b00) && (!div25 || (cur.year[3:2] == 2'b00));

  always_comb begin
    month_ok  = 1'b1;
    month_len = 5'd31;
    case (cur.month)
      MON_JAN, MON_MAR, MON_MAY, MON_JUL, MON_AUG, MON_OCT, MON_DEC: month_len = 5'd31;
      MON_APR, MON_JUN, MON_SEP, MON_NOV:                           month_len = 5'd30;
      MON_FEB:  month_len = leap ? 5'd29 : 5'd28;
      default:  month_ok = 1'b0;
    endcase
  end

  always_comb begin
    cur_next = cur;
    rc_next  = 1'b0;
    if (cmd1) begin
      cur_next = load1;
      rc_next  = 1'b1;
    end else if (cur.second < SEC_LAST) begin
      cur_next.second = cur.second + 1'b1;
    end else begin
      cur_next.second = '0;
      if (cur.minute < MIN_LAST) begin
        cur_next.minute = cur.minute + 1'b1;
      end else begin
        cur_next.minute = '0;
        if (cur.hour < HOUR_LAST) begin
          cur_next.hour = cur.hour + 1'b1;
        end else begin
          cur_next.hour = '0;
          rc_next       = 1'b1;
          // An invalid month leaves the date alone at midnight.
          if (month_ok) begin
            if (cur.day < month_len) begin
              cur_next.day = cur.day + 1'b1;
            end else begin
              cur_next.day = 5'd1;
              if (cur.month == MON_DEC) begin
                cur_next.month = MON_JAN;
                if (cur.year < YEAR_LAST) begin
                  cur_next.year = cur.year + 1'b1;
                end
              end else begin
                cur_next.month = cur.month + 1'b1;
              end
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur.second <= RST_SEC;
      cur.minute <= RST_MIN;
      cur.hour   <= RST_HOUR;
      cur.day    <= RST_DAY;
      cur.month  <= RST_MONTH;
      cur.year   <= RST_YEAR;
      v2         <= 1'b0;
    end else begin
      if (v1 && en2) begin
        cur <= cur_next;
      end
      if (en2) begin
        v2 <= v1;
      end
    end
    if (v1 && en2) begin
      tod2 <= cur_next;
      rc2  <= rc_next;
    end
  end

  // Zeller stage one: shifted year and century by reciprocal multiply.
  logic              early;
  logic [14:0]       yy;
  logic [27:0]       c_prod;

  assign early  = (tod2.month == MON_JAN) || (tod2.month == MON_FEB);
  assign yy     = {1'b0, tod2.year} + 15'd400 - {14'd0, early};
  assign c_prod = yy * 13'd5243;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en3) begin
      v3 <= v2;
    end
    if (v2 && en3) begin
      tod3  <= tod2;
      rc3   <= rc2;
      yy3   <= yy;
      cent3 <= c_prod[26:19];
      mm3   <= early ? tod2.month + 4'd12 : tod2.month;
    end
  end

  // Zeller stage two: year within century and the full sum.
  logic [14:0] cent_x100;
  logic [6:0]  yr_in_c;
  logic [10:0] sum;

  assign cent_x100 = {1'b0, cent3, 6'd0} + {2'd0, cent3, 5'd0} + {5'd0, cent3, 2'd0};
  assign yr_in_c   = 7'(yy3 - cent_x100);
  assign sum = 11'({6'd0, cent3[7:2]}) + 11'({cent3, 2'b00} + {3'd0, cent3})
             + 11'({4'd0, yr_in_c}) + 11'({6'd0, yr_in_c[6:2]})
             + 11'({5'd0, month_term(mm3)}) + 11'({6'd0, tod3.day}) + 11'd6;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en4) begin
      v4 <= v3;
    end
    if (v3 && en4) begin
      tod4 <= tod3;
      rc4  <= rc3;
      sum4 <= sum;
    end
  end

  // Zeller stage three: sum modulo 7 by reciprocal multiply and correction.
  logic [24:0]      m7_prod;
  logic [8:0]       m7_q;
  logic [WdayW-1:0] wday;

  assign m7_prod = sum4 * 14'd9363;
  assign m7_q    = m7_prod[24:16];
  assign wday    = WdayW'(sum4 - ({2'b00, m7_q} * 11'd7));

  // The weekday output register doubles as the held weekday for plain ticks.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      weekday   <= RST_WDAY;
    end else if (en5) begin
      out_valid <= v4;
      if (v4 && rc4) begin
        weekday <= wday;
      end
    end
    if (v4 && en5) begin
      second <= tod4.second;
      minute <= tod4.minute;
      hour   <= tod4.hour;
      day    <= tod4.day;
      month  <= tod4.month;
      year   <= tod4.year;
    end
  end

endmodule

>>> rtl/core/ccw_checker.sv
// Port-level checks for the calendar clock and the bind that attaches them.
module ccw_port_checks
  import ccw_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              out_valid,
  input logic              out_stall,
  input logic [SecW-1:0]   second,
  input logic [DayW-1:0]   day,
  input logic [YearW-1:0]  year,
  input logic [WdayW-1:0]  weekday
);

  // Reset must empty the pipeline.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // The weekday comes out of a modulo 7 unit or the reset value.
  a_wday_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (weekday <= WDAY_LAST))
    else $error("weekday out of range");

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(second) && $stable(day) && $stable(year)
      && $stable(weekday))
    else $error("result changed while stalled");

endmodule

bind calendar_clock_with_weekday ccw_port_checks u_ccw_port_checks (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .second    (second),
  .day       (day),
  .year      (year),
  .weekday   (weekday)
);

>>> tb/ccw_tb_pkg.sv
// Command codes shared by the calendar clock testbench files.
package ccw_tb_pkg;

  typedef enum logic {
    CMD_TICK = 1'b0,
    CMD_LOAD = 1'b1
  } clock_cmd_e;

endpackage

>>> tb/ccw_checker.sv
// Checker that predicts every calendar reading and compares it with the block output.
module ccw_checker
  import ccw_pkg::*;
  import ccw_tb_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic              cmd,
  input  logic [SecW-1:0]   load_second,
  input  logic [MinW-1:0]   load_minute,
  input  logic [HourW-1:0]  load_hour,
  input  logic [DayW-1:0]   load_day,
  input  logic [MonthW-1:0] load_month,
  input  logic [YearW-1:0]  load_year,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [SecW-1:0]   second,
  input  logic [MinW-1:0]   minute,
  input  logic [HourW-1:0]  hour,
  input  logic [DayW-1:0]   day,
  input  logic [MonthW-1:0] month,
  input  logic [YearW-1:0]  year,
  input  logic [WdayW-1:0]  weekday,
  output int                fail_count,
  output int                pending
);

  localparam int ReportLimit = 50;

  typedef struct packed {
    logic [SecW-1:0]   sec;
    logic [MinW-1:0]   min;
    logic [HourW-1:0]  hour;
    logic [DayW-1:0]   day;
    logic [MonthW-1:0] month;
    logic [YearW-1:0]  year;
    logic [WdayW-1:0]  wday;
  } reading_t;

  reading_t expected_readings[$];
  reading_t clock_now;
  reading_t oldest;

  // The year is shifted by one full 400-year cycle so that year 0 stays positive.
  function automatic logic [WdayW-1:0] zeller_weekday(input reading_t r);
    int unsigned yy, mm, c, rem;
    yy = r.year + 400;
    mm = r.month;
    if (r.month == MON_JAN || r.month == MON_FEB) begin
      yy = yy - 1;
      mm = mm + 12;
    end
    c = yy / 100;
    rem = yy % 100;
    return WdayW'((c / 4 + 5 * c + rem + rem / 4 + (13 * (mm + 1)) / 5 + r.day + 6) % 7);
  endfunction

  // Zero marks a month code that has no length; such a date never advances.
  function automatic int unsigned days_in_month(input reading_t r);
    case (r.month)
      MON_JAN, MON_MAR, MON_MAY, MON_JUL, MON_AUG, MON_OCT, MON_DEC: return 31;
      MON_APR, MON_JUN, MON_SEP, MON_NOV: return 30;
      MON_FEB: begin
        if ((r.year % 4 == 0 && r.year % 100 != 0) || r.year % 400 == 0) return 29;
        return 28;
      end
      default: return 0;
    endcase
  endfunction

  function automatic reading_t next_reading(input reading_t r, input logic c,
                                            input reading_t ld);
    int unsigned len;
    if (c == CMD_LOAD) begin
      r = ld;
      r.wday = zeller_weekday(r);
    end else if (r.sec < SEC_LAST) begin
      r.sec++;
    end else begin
      r.sec = '0;
      if (r.min < MIN_LAST) begin
        r.min++;
      end else begin
        r.min = '0;
        if (r.hour < HOUR_LAST) begin
          r.hour++;
        end else begin
          r.hour = '0;
          len = days_in_month(r);
          if (len != 0) begin
            if (r.day < len) begin
              r.day++;
            end else begin
              r.day = DayW'(1);
              if (r.month == MON_DEC) begin
                r.month = MON_JAN;
                if (r.year < YEAR_LAST) r.year++;
              end else begin
                r.month++;
              end
            end
          end
          r.wday = zeller_weekday(r);
        end
      end
    end
    return r;
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      fail_count++;
      if (fail_count <= ReportLimit)
        $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      clock_now = '{RST_SEC, RST_MIN, RST_HOUR, RST_DAY, RST_MONTH, RST_YEAR, RST_WDAY};
      expected_readings.delete();
      fail_count = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_readings.size() == 0) begin
          fail_count++;
          if (fail_count <= ReportLimit)
            $display("%0t: reading expected none, got %0d:%0d:%0d %0d/%0d/%0d wd %0d",
                     $time, hour, minute, second, day, month, year, weekday);
        end else begin
          oldest = expected_readings.pop_front();
          check_field("second", oldest.sec, second);
          check_field("minute", oldest.min, minute);
          check_field("hour", oldest.hour, hour);
          check_field("day", oldest.day, day);
          check_field("month", oldest.month, month);
          check_field("year", oldest.year, year);
          check_field("weekday", oldest.wday, weekday);
        end
      end
      if (in_valid && !in_stall) begin
        clock_now = next_reading(clock_now, cmd, '{load_second, load_minute, load_hour,
                                                   load_day, load_month, load_year, '0});
        expected_readings.push_back(clock_now);
      end
    end
    pending = expected_readings.size();
  end

endmodule

>>> tb/tb_top.sv
// Top of the calendar clock testbench: clock, reset, stimulus and the verdict.
module tb_top;
  import ccw_pkg::*;
  import ccw_tb_pkg::*;

  localparam int ItemTarget    = 1300;
  localparam int QuietFrom     = 1150;
  localparam int HoldAt        = 400;
  localparam int HoldCycles    = 300;
  localparam int DrainAt       = 800;
  localparam int DrainCycles   = 16;
  localparam int WatchdogLimit = 3000;

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_stall;
  logic              cmd;
  logic [SecW-1:0]   load_second;
  logic [MinW-1:0]   load_minute;
  logic [HourW-1:0]  load_hour;
  logic [DayW-1:0]   load_day;
  logic [MonthW-1:0] load_month;
  logic [YearW-1:0]  load_year;
  logic              out_valid;
  logic              out_stall;
  logic [SecW-1:0]   second;
  logic [MinW-1:0]   minute;
  logic [HourW-1:0]  hour;
  logic [DayW-1:0]   day;
  logic [MonthW-1:0] month;
  logic [YearW-1:0]  year;
  logic [WdayW-1:0]  weekday;

  int fail_count;
  int pending;
  int sent;
  int idle_odds;
  bit long_hold_req;

  calendar_clock_with_weekday i_dut (
    .clk, .rst, .in_valid, .in_stall, .cmd,
    .load_second, .load_minute, .load_hour, .load_day, .load_month, .load_year,
    .out_valid, .out_stall, .second, .minute, .hour, .day, .month, .year, .weekday
  );

  ccw_checker i_checker (
    .clk, .rst, .in_valid, .in_stall, .cmd,
    .load_second, .load_minute, .load_hour, .load_day, .load_month, .load_year,
    .out_valid, .out_stall, .second, .minute, .hour, .day, .month, .year, .weekday,
    .fail_count, .pending
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Drives one item at the falling edge and holds it until it is accepted.
  task automatic offer_item(input clock_cmd_e c, input logic [SecW-1:0] s,
                            input logic [MinW-1:0] mi, input logic [HourW-1:0] h,
                            input logic [DayW-1:0] d, input logic [MonthW-1:0] mo,
                            input logic [YearW-1:0] y);
    if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    in_valid    = 1'b1;
    cmd         = c;
    load_second = s;
    load_minute = mi;
    load_hour   = h;
    load_day    = d;
    load_month  = mo;
    load_year   = y;
    do @(posedge clk); while (in_stall);
    sent++;
    @(negedge clk);
  endtask

  // A tick carries random load fields, which the block must ignore.
  task automatic offer_tick();
    offer_item(CMD_TICK, SecW'($urandom), MinW'($urandom), HourW'($urandom),
               DayW'($urandom), MonthW'($urandom), YearW'($urandom));
  endtask

  task automatic load_then_tick(input logic [SecW-1:0] s, input logic [MinW-1:0] mi,
                                input logic [HourW-1:0] h, input logic [DayW-1:0] d,
                                input logic [MonthW-1:0] mo, input logic [YearW-1:0] y);
    offer_item(CMD_LOAD, s, mi, h, d, mo, y);
    offer_tick();
  endtask

  initial begin : receiver
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_stall = 1'b1;
        repeat (HoldCycles) @(negedge clk);
        out_stall = 1'b0;
      end else if (!rst && idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
        out_stall = 1'b1;
        repeat ($urandom_range(1, 16)) @(negedge clk);
        out_stall = 1'b0;
      end
    end
  end

  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WatchdogLimit) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("FAIL");
    $finish;
  end

  initial begin : stimulus
    logic [SecW-1:0]   s;
    logic [MinW-1:0]   mi;
    logic [HourW-1:0]  h;
    logic [DayW-1:0]   d;
    logic [MonthW-1:0] mo;
    logic [YearW-1:0]  y;
    bit hold_done;
    bit drain_done;
    int ticks;

    rst = 1'b1;
    in_valid = 1'b0;
    cmd = CMD_TICK;
    load_second = '0;
    load_minute = '0;
    load_hour = '0;
    load_day = '0;
    load_month = '0;
    load_year = '0;
    sent = 0;
    idle_odds = 0;
    long_hold_req = 1'b0;
    hold_done = 1'b0;
    drain_done = 1'b0;
    repeat (8) @(negedge clk);
    rst = 1'b0;

    idle_odds = 5;
    offer_tick();
    offer_tick();
    load_then_tick(0, 0, 0, 1, MON_JAN, 1);
    load_then_tick(SEC_LAST, MIN_LAST, HOUR_LAST, 31, MON_DEC, YEAR_LAST);
    load_then_tick(SEC_LAST, MIN_LAST, HOUR_LAST, 28, MON_FEB, 2100);
    load_then_tick(SEC_LAST, MIN_LAST, HOUR_LAST, 28, MON_FEB, 2000);
    load_then_tick(SEC_LAST, MIN_LAST, HOUR_LAST, 29, MON_FEB, 2024);
    load_then_tick(SEC_LAST, MIN_LAST, HOUR_LAST, 30, MON_APR, 2023);
    load_then_tick(SEC_LAST, MIN_LAST, HOUR_LAST, 5, 4'd0, 2021);
    load_then_tick(SEC_LAST, MIN_LAST, HOUR_LAST, 5, 4'd13, 2021);
    load_then_tick('1, '1, '1, '1, '1, '1);
    load_then_tick(SEC_LAST, MIN_LAST, HOUR_LAST, 0, MON_MAR, 2022);
    load_then_tick(10, 20, 5, 1, MON_JAN, 0);
    load_then_tick(0, 0, 0, 29, MON_FEB, 0);
    // Crossing midnight into a Sunday.
    load_then_tick(SEC_LAST, MIN_LAST, HOUR_LAST, 16, MON_OCT, 2021);
    load_then_tick(58, MIN_LAST, HOUR_LAST, 31, MON_DEC, 2021);
    offer_tick();

    while (sent < ItemTarget) begin
      if (sent >= QuietFrom || (sent >= HoldAt - 50 && sent < HoldAt + 100)) idle_odds = 0;
      else if ((sent / 100) % 3 == 2) idle_odds = 3;
      else idle_odds = 8;

      if (!hold_done && sent >= HoldAt) begin
        hold_done = 1'b1;
        long_hold_req = 1'b1;
      end

      // Let every reading come back before the sender resumes.
      if (!drain_done && sent >= DrainAt) begin
        drain_done = 1'b1;
        in_valid = 1'b0;
        while (pending != 0) @(negedge clk);
      end

      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13: begin
          // Near-midnight load followed by ticks, so that the date logic is exercised.
          s  = SecW'($urandom_range(50, 59));
          mi = ($urandom_range(0, 3) == 0) ? MinW'($urandom_range(0, 59)) : MIN_LAST;
          h  = ($urandom_range(0, 4) == 0) ? HourW'($urandom_range(0, 23)) : HOUR_LAST;
          mo = MonthW'($urandom_range(1, 12));
          d  = ($urandom_range(0, 1) == 0) ? DayW'($urandom_range(27, 31))
                                           : DayW'($urandom_range(1, 31));
          case ($urandom_range(0, 4))
            0: y = YearW'($urandom_range(1, 9999));
            1: y = YEAR_LAST;
            2: y = YearW'(100 * $urandom_range(1, 99));
            3: y = YearW'(4 * $urandom_range(1, 2499));
            default: y = YearW'($urandom_range(0, 3));
          endcase
          offer_item(CMD_LOAD, s, mi, h, d, mo, y);
          ticks = $urandom_range(1, 15);
        end
        14, 15, 16: begin
          offer_item(CMD_LOAD, SecW'($urandom), MinW'($urandom), HourW'($urandom),
                     DayW'($urandom), MonthW'($urandom), YearW'($urandom));
          ticks = $urandom_range(0, 3);
        end
        default: ticks = $urandom_range(1, 25);
      endcase
      repeat (ticks) offer_tick();
    end

    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
    if (fail_count == 0 && pending == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
